### rtl/stc_pkg.sv
// shared types, constants and codes for the stereo tone control block
// no dependencies; every rtl file refers to it by scoped names
`default_nettype none

package stc_pkg;

    // field and register widths
    localparam int SAMPLE_W = 16;
    localparam int VOLUME_W = 6;
    localparam int GAIN_W   = 5;
    localparam int TPS_W    = 18;
    localparam int SEC_W    = 6;
    localparam int MIN_W    = 8;
    localparam int CFG_W    = 18;

    // shared multiply-accumulate unit widths
    localparam int OPND_W = 17;
    localparam int ACC_W  = 34;
    localparam int SUM_W  = 22;

    // filter and limit constants
    localparam logic [OPND_W-1:0] LP_IN_COEF   = 17'd1000;
    localparam logic [OPND_W-1:0] LP_FB_COEF   = 17'd31768;
    localparam logic signed [SUM_W-1:0] SUM_LIMIT_POS = 22'sd32766;
    localparam logic signed [SUM_W-1:0] SUM_LIMIT_NEG = -22'sd32766;
    localparam logic [SEC_W-1:0] SECS_PER_MIN  = 6'd60;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_VOLUME      = 2'd0,
        CFG_TREBLE_GAIN = 2'd1,
        CFG_BASS_GAIN   = 2'd2,
        CFG_TICKS_PER_S = 2'd3
    } cfg_index_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VOL,
        ST_LPX,
        ST_LPF,
        ST_TRE,
        ST_BAS,
        ST_SUM,
        ST_DONE
    } state_t;

    // one operation for the shared multiply-accumulate unit
    typedef struct packed {
        logic              en;
        logic              accum;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
    } mac_op_t;

endpackage

`default_nettype wire

### rtl/stc_mac.sv
// shared signed 17x17 multiply-accumulate unit with a registered accumulator
// depends on stc_pkg
`default_nettype none

module stc_mac (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire stc_pkg::mac_op_t               op,
    output logic signed [stc_pkg::ACC_W-1:0]    acc
);

    logic signed [stc_pkg::OPND_W-1:0] opnd_a;
    logic signed [stc_pkg::OPND_W-1:0] opnd_b;
    logic signed [stc_pkg::ACC_W-1:0]  prod;
    logic signed [stc_pkg::ACC_W-1:0]  acc_reg;
    logic signed [stc_pkg::ACC_W-1:0]  acc_next;

    // multiply, then either load or add into the accumulator
    assign opnd_a = $signed(op.a);
    assign opnd_b = $signed(op.b);
    assign prod   = opnd_a * opnd_b;

    always_comb
    begin
        acc_next = acc_reg;
        if (op.en)
        begin
            if (op.accum)
                acc_next = acc_reg + prod;
            else
                acc_next = prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

### rtl/stc_play_clock.sv
// play clock: tick counter feeding seconds and wrapping minutes
// depends on stc_pkg
`default_nettype none

module stc_play_clock (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic [stc_pkg::TPS_W-1:0]    ticks_per_second,
    output logic [stc_pkg::SEC_W-1:0]         seconds,
    output logic [stc_pkg::MIN_W-1:0]         minutes
);

    logic [stc_pkg::TPS_W-1:0] tick_reg;
    logic [stc_pkg::TPS_W-1:0] tick_next;
    logic [stc_pkg::SEC_W-1:0] sec_reg;
    logic [stc_pkg::SEC_W-1:0] sec_next;
    logic [stc_pkg::MIN_W-1:0] min_reg;
    logic [stc_pkg::MIN_W-1:0] min_next;
    logic [stc_pkg::TPS_W-1:0] tick_inc;
    logic [stc_pkg::SEC_W-1:0] sec_inc;

    assign tick_inc = tick_reg + 1'b1;
    assign sec_inc  = sec_reg + 1'b1;

    // one tick per processed word, carry into seconds and minutes
    always_comb
    begin
        tick_next = tick_reg;
        sec_next  = sec_reg;
        min_next  = min_reg;
        if (advance)
        begin
            if (tick_inc >= ticks_per_second)
            begin
                tick_next = '0;
                if (sec_inc >= stc_pkg::SECS_PER_MIN)
                begin
                    sec_next = '0;
                    min_next = min_reg + 1'b1;
                end
                else
                begin
                    sec_next = sec_inc;
                end
            end
            else
            begin
                tick_next = tick_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            sec_reg  <= '0;
            min_reg  <= '0;
        end
        else
        begin
            tick_reg <= tick_next;
            sec_reg  <= sec_next;
            min_reg  <= min_next;
        end
    end

    assign seconds = sec_reg;
    assign minutes = min_reg;

endmodule

`default_nettype wire

### rtl/stereo_tone_control_i2s_feed.sv
// Stereo tone control feeding an I2S DAC; depends on stc_pkg, stc_mac, stc_play_clock.
// A sample steps through VOL, LPX, LPF, TRE, BAS, SUM and DONE after acceptance, a paused
// item goes straight to DONE; a new item is taken only once the last leaves DONE, and the five
// multiplies run one after another through the single multiply-accumulate unit.
// Reset: asynchronous active low; filters, play clock and channel phase clear,
// registers return to volume 8, gains 0, 88200 ticks per second.
`default_nettype none

module stereo_tone_control_i2s_feed (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [stc_pkg::CFG_W-1:0]     cfg_data,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [stc_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                          paused,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [stc_pkg::SAMPLE_W-1:0]       dac_word,
    output logic                               left_select,
    output logic [stc_pkg::SEC_W-1:0]          play_seconds,
    output logic [stc_pkg::MIN_W-1:0]          play_minutes
);

    localparam int SW = stc_pkg::SAMPLE_W;
    localparam int OW = stc_pkg::OPND_W;

    // configuration registers
    logic [stc_pkg::VOLUME_W-1:0] volume_reg;
    logic [stc_pkg::GAIN_W-1:0]   treble_reg;
    logic [stc_pkg::GAIN_W-1:0]   bass_reg;
    logic [stc_pkg::TPS_W-1:0]    tps_reg;

    // sequencer and per-item registers
    stc_pkg::state_t state_reg, state_next;
    logic [SW-1:0]   in_sample_reg;
    logic [SW-1:0]   x_reg;
    logic [OW-1:0]   high_reg;
    logic [OW-1:0]   low_reg;
    logic [SW-1:0]   word_reg;
    logic            toggle_reg;
    logic            carried_reg;

    // channel filter state
    logic [SW-1:0] lp_left_reg, lp_right_reg;
    logic [SW-1:0] hp_left_reg, hp_right_reg;
    logic [SW-1:0] prev_left_reg, prev_right_reg;

    // output register
    logic            out_valid_reg;
    logic [SW-1:0]   out_word_reg;
    logic            out_left_reg;
    logic [stc_pkg::SEC_W-1:0] out_sec_reg;
    logic [stc_pkg::MIN_W-1:0] out_min_reg;

    stc_pkg::mac_op_t mac_op;
    logic signed [stc_pkg::ACC_W-1:0] acc;
    logic            clock_advance;
    logic [stc_pkg::SEC_W-1:0] seconds;
    logic [stc_pkg::MIN_W-1:0] minutes;

    logic            in_xfer;
    logic            out_free;
    logic            is_left;
    logic [SW-1:0]   lp_sel, hp_sel, prev_sel;
    logic [SW-1:0]   x_scaled;
    logic signed [SW+1:0] high_sum;
    logic signed [stc_pkg::SUM_W-1:0] tone_sum;
    logic signed [stc_pkg::SUM_W-1:0] tone_sat;
    logic [SW-1:0]   sat_bits;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != stc_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign is_left  = toggle_reg;

    assign lp_sel   = is_left ? lp_left_reg   : lp_right_reg;
    assign hp_sel   = is_left ? hp_left_reg   : hp_right_reg;
    assign prev_sel = is_left ? prev_left_reg : prev_right_reg;

    // volume-scaled sample: floor of product / 32, low 16 bits kept
    assign x_scaled = acc[SW+4:5];

    // high-pass: floor((x - prev + hp) / 2)
    assign high_sum = {{2{x_scaled[SW-1]}}, x_scaled} - {{2{prev_sel[SW-1]}}, prev_sel}
                    + {{2{hp_sel[SW-1]}}, hp_sel};

    // tone sum and saturation
    assign tone_sum = $signed(acc[stc_pkg::SUM_W-1:0])
                    + $signed({{(stc_pkg::SUM_W-SW){x_reg[SW-1]}}, x_reg});

    always_comb
    begin
        if (tone_sum > stc_pkg::SUM_LIMIT_POS)
            tone_sat = stc_pkg::SUM_LIMIT_POS;
        else if (tone_sum < stc_pkg::SUM_LIMIT_NEG)
            tone_sat = stc_pkg::SUM_LIMIT_NEG;
        else
            tone_sat = tone_sum;
    end

    assign sat_bits = tone_sat[SW-1:0];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= 6'd8;
            treble_reg <= '0;
            bass_reg   <= '0;
            tps_reg    <= 18'd88200;
        end
        else if (cfg_we)
        begin
            case (stc_pkg::cfg_index_t'(cfg_index))
                stc_pkg::CFG_VOLUME:      volume_reg <= cfg_data[stc_pkg::VOLUME_W-1:0];
                stc_pkg::CFG_TREBLE_GAIN: treble_reg <= cfg_data[stc_pkg::GAIN_W-1:0];
                stc_pkg::CFG_BASS_GAIN:   bass_reg   <= cfg_data[stc_pkg::GAIN_W-1:0];
                stc_pkg::CFG_TICKS_PER_S: tps_reg    <= cfg_data[stc_pkg::TPS_W-1:0];
                default: ;
            endcase
        end
    end

    // next state and multiplier operands
    always_comb
    begin
        state_next    = state_reg;
        mac_op        = '0;
        clock_advance = 1'b0;
        case (state_reg)
            stc_pkg::ST_IDLE:
            begin
                if (in_xfer)
                    state_next = paused ? stc_pkg::ST_DONE : stc_pkg::ST_VOL;
            end
            stc_pkg::ST_VOL:
            begin
                mac_op.en  = 1'b1;
                mac_op.a   = {in_sample_reg[SW-1], in_sample_reg};
                mac_op.b   = {{(OW-stc_pkg::VOLUME_W){1'b0}}, volume_reg};
                state_next = stc_pkg::ST_LPX;
            end
            stc_pkg::ST_LPX:
            begin
                mac_op.en  = 1'b1;
                mac_op.a   = {x_scaled[SW-1], x_scaled};
                mac_op.b   = stc_pkg::LP_IN_COEF;
                state_next = stc_pkg::ST_LPF;
            end
            stc_pkg::ST_LPF:
            begin
                mac_op.en    = 1'b1;
                mac_op.accum = 1'b1;
                mac_op.a     = {lp_sel[SW-1], lp_sel};
                mac_op.b     = stc_pkg::LP_FB_COEF;
                state_next   = stc_pkg::ST_TRE;
            end
            stc_pkg::ST_TRE:
            begin
                mac_op.en  = 1'b1;
                mac_op.a   = {{3{high_reg[OW-1]}}, high_reg[OW-1:3]};
                mac_op.b   = {{(OW-stc_pkg::GAIN_W){treble_reg[stc_pkg::GAIN_W-1]}},
                              treble_reg};
                state_next = stc_pkg::ST_BAS;
            end
            stc_pkg::ST_BAS:
            begin
                mac_op.en    = 1'b1;
                mac_op.accum = 1'b1;
                mac_op.a     = {{3{low_reg[OW-1]}}, low_reg[OW-1:3]};
                mac_op.b     = {{(OW-stc_pkg::GAIN_W){bass_reg[stc_pkg::GAIN_W-1]}},
                                bass_reg};
                state_next   = stc_pkg::ST_SUM;
            end
            stc_pkg::ST_SUM:
            begin
                clock_advance = 1'b1;
                state_next    = stc_pkg::ST_DONE;
            end
            stc_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = stc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = stc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= stc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // channel phase and carried bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg  <= 1'b0;
            carried_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer && !paused)
                toggle_reg <= ~toggle_reg;
            if (state_reg == stc_pkg::ST_SUM)
                carried_reg <= sat_bits[0];
        end
    end

    // filter state, committed once the tone sum is formed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_left_reg    <= '0;
            lp_right_reg   <= '0;
            hp_left_reg    <= '0;
            hp_right_reg   <= '0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
        end
        else if (state_reg == stc_pkg::ST_SUM)
        begin
            if (is_left)
            begin
                lp_left_reg   <= low_reg[SW-1:0];
                hp_left_reg   <= high_reg[SW-1:0];
                prev_left_reg <= x_reg;
            end
            else
            begin
                lp_right_reg   <= low_reg[SW-1:0];
                hp_right_reg   <= high_reg[SW-1:0];
                prev_right_reg <= x_reg;
            end
        end
    end

    // per-item datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_sample_reg <= sample;
            word_reg      <= '0;
        end
        if (state_reg == stc_pkg::ST_LPX)
        begin
            x_reg    <= x_scaled;
            high_reg <= high_sum[SW+1:1];
        end
        if (state_reg == stc_pkg::ST_TRE)
            low_reg <= acc[SW+OW-2:SW-1];
        if (state_reg == stc_pkg::ST_SUM)
            word_reg <= {carried_reg, sat_bits[SW-1:1]};
    end

    // output register, loaded when the item is done and the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == stc_pkg::ST_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == stc_pkg::ST_DONE && out_free)
        begin
            out_word_reg <= word_reg;
            out_left_reg <= toggle_reg;
            out_sec_reg  <= seconds;
            out_min_reg  <= minutes;
        end
    end

    stc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .acc   (acc)
    );

    stc_play_clock u_play_clock (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (clock_advance),
        .ticks_per_second (tps_reg),
        .seconds          (seconds),
        .minutes          (minutes)
    );

    assign out_valid    = out_valid_reg;
    assign dac_word     = out_word_reg;
    assign left_select  = out_left_reg;
    assign play_seconds = out_sec_reg;
    assign play_minutes = out_min_reg;

endmodule

`default_nettype wire

### rtl/stc_checker.sv
// port-level checks for the stereo tone control block, bound to the top level
// depends on stereo_tone_control_i2s_feed and stc_pkg
`default_nettype none

module stc_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [stc_pkg::SEC_W-1:0]     play_seconds
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // an accepted item keeps the input side busy the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

    // a new result only follows an item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in flight");

    // seconds never reach a full minute
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> play_seconds < stc_pkg::SECS_PER_MIN)
        else $error("seconds out of range");

endmodule

bind stereo_tone_control_i2s_feed stc_checker u_stc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .play_seconds (play_seconds)
);

`default_nettype wire

### sim/stereo_tone_control_i2s_feed_test.sv
// self-checking testbench for the stereo tone control / i2s feed block
// depends on stc_pkg and stereo_tone_control_i2s_feed from the rtl folder
`timescale 1ns / 1ps

module stereo_tone_control_i2s_feed_test;

    localparam int      STUCK_LIMIT   = 4000;
    localparam int      DRAIN_PAD     = 12;
    localparam int      RANDOM_PHASES = 8;
    localparam int      PHASE_ITEMS   = 195;
    localparam longint  LOWPASS_IN    = 1000;
    localparam longint  LOWPASS_FB    = 31768;
    localparam longint  TONE_CEIL     = 32766;
    localparam int      SECS_IN_MIN   = 60;

    typedef struct {
        logic signed [15:0] smp;
        logic               pz;
    } feed_item_t;

    typedef struct {
        logic [15:0] word;
        logic        left;
        logic [5:0]  secs;
        logic [7:0]  mins;
    } dac_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = stc_pkg::CFG_VOLUME;
    logic [stc_pkg::CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [stc_pkg::SAMPLE_W-1:0] sample = '0;
    logic paused = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [stc_pkg::SAMPLE_W-1:0] dac_word;
    logic left_select;
    logic [stc_pkg::SEC_W-1:0] play_seconds;
    logic [stc_pkg::MIN_W-1:0] play_minutes;

    // pending samples for the driver and words the block still owes
    feed_item_t  feed_q[$];
    dac_result_t tone_q[$];

    // predictor copy of the registers
    logic [5:0]         vol_reg;
    logic signed [4:0]  treble_reg;
    logic signed [4:0]  bass_reg;
    logic [17:0]        tps_reg;

    // predictor copy of the state, channel index 1 is left
    logic signed [15:0] lp_state [2];
    logic signed [15:0] hp_state [2];
    logic signed [15:0] prior_in [2];
    logic               phase_left;
    logic               lsb_carry;
    logic [17:0]        tick_ct;
    logic [5:0]         sec_ct;
    logic [7:0]         min_ct;

    logic in_accepted = 1'b0;
    int   errors = 0;
    int   words_checked = 0;
    int   paused_seen = 0;
    int   settings_used = 0;
    int   stuck_cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   free_left = 0;

    stereo_tone_control_i2s_feed uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .paused       (paused),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dac_word     (dac_word),
        .left_select  (left_select),
        .play_seconds (play_seconds),
        .play_minutes (play_minutes)
    );

    always #5 clk = ~clk;

    function automatic longint wrap16(input longint v);
        logic signed [15:0] w;
        w = v[15:0];
        return longint'(w);
    endfunction

    // tone control, i2s bit alignment and play clock for one transfer
    task automatic predict_dac_word(input logic signed [15:0] smp, input logic pz);
        dac_result_t r;
        longint      x;
        longint      low;
        longint      high;
        longint      tone;
        int          ch;
        logic [15:0] bits;
        r.word = '0;
        if (!pz) begin
            phase_left = ~phase_left;
            ch = phase_left ? 1 : 0;
            x = wrap16((longint'(smp) * longint'(vol_reg)) >>> 5);
            low = (LOWPASS_IN * x + LOWPASS_FB * longint'(lp_state[ch])) >>> 15;
            high = (x - longint'(prior_in[ch]) + longint'(hp_state[ch])) >>> 1;
            lp_state[ch] = low[15:0];
            hp_state[ch] = high[15:0];
            prior_in[ch] = x[15:0];
            tone = x + (high >>> 3) * longint'(treble_reg)
                 + (low >>> 3) * longint'(bass_reg);
            if (tone > TONE_CEIL)
                tone = TONE_CEIL;
            if (tone < -TONE_CEIL)
                tone = -TONE_CEIL;
            bits = tone[15:0];
            r.word = {lsb_carry, bits[15:1]};
            lsb_carry = bits[0];
            // play clock: ticks roll into seconds, seconds into minutes
            tick_ct = tick_ct + 18'd1;
            if (tick_ct >= tps_reg) begin
                tick_ct = '0;
                sec_ct = sec_ct + 6'd1;
                if (sec_ct >= 6'(SECS_IN_MIN)) begin
                    sec_ct = '0;
                    min_ct = min_ct + 8'd1;
                end
            end
        end
        else
            paused_seen++;
        r.left = phase_left;
        r.secs = sec_ct;
        r.mins = min_ct;
        tone_q.push_back(r);
    endtask

    function automatic void queue_sample(input logic signed [15:0] smp, input logic pz);
        feed_item_t it;
        it.smp = smp;
        it.pz = pz;
        feed_q.push_back(it);
    endfunction

    // full-scale extremes, small values near zero, or anything
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input stc_pkg::cfg_index_t idx, input logic [17:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            stc_pkg::CFG_VOLUME:      vol_reg = value[5:0];
            stc_pkg::CFG_TREBLE_GAIN: treble_reg = value[4:0];
            stc_pkg::CFG_BASS_GAIN:   bass_reg = value[4:0];
            stc_pkg::CFG_TICKS_PER_S: tps_reg = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int vol, input int treble, input int bass,
                                  input int tps);
        write_reg(stc_pkg::CFG_VOLUME, 18'(vol));
        write_reg(stc_pkg::CFG_TREBLE_GAIN, 18'(treble));
        write_reg(stc_pkg::CFG_BASS_GAIN, 18'(bass));
        write_reg(stc_pkg::CFG_TICKS_PER_S, 18'(tps));
        settings_used++;
    endtask

    // block is idle once every queued sample went in and every word came out
    task automatic drain();
        while (feed_q.size() != 0 || in_valid || tone_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(negedge clk) begin
        feed_item_t it;
        if (rst_n && (!in_valid || in_accepted)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (feed_q.size() != 0) begin
                it = feed_q.pop_front();
                sample <= it.smp;
                paused <= it.pz;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: stall runs and free runs, sometimes a long free stretch
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (free_left > 0) begin
            free_left <= free_left - 1;
            out_stall <= 1'b0;
        end
        else begin
            if ($urandom_range(0, 3) == 0) begin
                stall_left <= 0;
                free_left <= $urandom_range(40, 150);
            end
            else begin
                stall_left <= $urandom_range(1, 10);
                free_left <= $urandom_range(0, 8);
            end
            out_stall <= 1'b0;
        end
    end

    // check output transfers, predict input transfers, watch for hangs
    always @(posedge clk) begin
        dac_result_t want;
        in_accepted <= in_valid && !in_stall;
        if (out_valid && !out_stall) begin
            if (tone_q.size() == 0) begin
                $error("unexpected output transfer, dac_word %h", dac_word);
                errors++;
            end
            else begin
                want = tone_q.pop_front();
                words_checked++;
                if (dac_word !== want.word) begin
                    $error("dac_word expected %h actual %h", want.word, dac_word);
                    errors++;
                end
                if (left_select !== want.left) begin
                    $error("left_select expected %b actual %b", want.left, left_select);
                    errors++;
                end
                if (play_seconds !== want.secs) begin
                    $error("play_seconds expected %0d actual %0d", want.secs, play_seconds);
                    errors++;
                end
                if (play_minutes !== want.mins) begin
                    $error("play_minutes expected %0d actual %0d", want.mins, play_minutes);
                    errors++;
                end
            end
        end
        if (in_valid && !in_stall)
            predict_dac_word(sample, paused);
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (feed_q.size() == 0 && tone_q.size() == 0 && !in_valid))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("no transfer for %0d cycles with work outstanding", STUCK_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus
    initial begin
        int need;
        int g_treble;
        int g_bass;
        int vol;
        int tps;
        vol_reg = 6'd8;
        treble_reg = '0;
        bass_reg = '0;
        tps_reg = 18'd88200;
        for (int c = 0; c < 2; c++) begin
            lp_state[c] = '0;
            hp_state[c] = '0;
            prior_in[c] = '0;
        end
        phase_left = 1'b0;
        lsb_carry = 1'b0;
        tick_ct = '0;
        sec_ct = '0;
        min_ct = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: paused before any sample, extremes, alternating bits
        queue_sample(16'sh0000, 1'b1);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh1234, 1'b1);
        queue_sample(16'sh0000, 1'b0);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sh5555, 1'b0);
        queue_sample(16'shAAAA, 1'b0);
        drain();

        // unity volume, gains of 10: saturation both ways, fast play clock
        apply_settings(32, 10, 10, 3);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7FFF, 1'b1);
        queue_sample(16'sh0001, 1'b0);
        queue_sample(-16'sd1, 1'b0);
        drain();

        // volume above unity wraps, widest gains, every word is a second
        apply_settings(63, -16, 15, 0);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh4000, 1'b0);
        queue_sample(16'shC000, 1'b0);
        queue_sample(16'sh0001, 1'b0);
        drain();

        // muted, opposite widest gains, longest second
        apply_settings(0, 15, -16, 18'h3FFFF);
        queue_sample(16'sh7FFF, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7FFF, 1'b1);
        queue_sample(16'sh0100, 1'b0);
        drain();

        // random register settings, each with a random stream
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            vol = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 63)
                                                : $urandom_range(0, 32);
            g_treble = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 31)) - 16
                                                     : int'($urandom_range(0, 20)) - 10;
            g_bass = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 31)) - 16
                                                   : int'($urandom_range(0, 20)) - 10;
            case ($urandom_range(0, 6))
                0: tps = 0;
                1: tps = 1;
                2: tps = $urandom_range(2, 20);
                3: tps = $urandom_range(100000, 200000);
                4: tps = 18'h3FFFF;
                default: tps = $urandom_range(2, 300);
            endcase
            apply_settings(vol, g_treble, g_bass, tps);
            for (int k = 0; k < PHASE_ITEMS; k++)
                queue_sample(pick_sample(), $urandom_range(0, 7) == 0);
            drain();
        end

        // one second per word until the seconds carry into the minutes twice
        apply_settings($urandom_range(8, 32), int'($urandom_range(0, 20)) - 10,
                       int'($urandom_range(0, 20)) - 10, 1);
        need = 2 * SECS_IN_MIN - int'(sec_ct) + 10;
        while (need > 0) begin
            if ($urandom_range(0, 49) == 0)
                queue_sample(pick_sample(), 1'b1);
            else begin
                queue_sample(pick_sample(), 1'b0);
                need--;
            end
        end
        drain();

        $display("checked %0d dac words, %0d of them paused, over %0d register settings",
                 words_checked, paused_seen, settings_used);
        $display("play clock carried seconds into minutes, ending at %0d min %0d s",
                 min_ct, sec_ct);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
